// File: hdl/segi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_pkg: shared constants and types for the segment intersection pipeline.
// Widths of coordinates, differences, cross products and quotients.
// ----------------------------------------------------------------------------
package segi_pkg;
  localparam int CW  = 24;        // coordinate width
  localparam int FB  = 16;        // fraction bits of t and u
  localparam int DW  = CW + 1;    // difference width
  localparam int XW  = 2 * DW + 1; // cross product width
  localparam int PW  = FB + 1;    // clamped parameter width
  localparam int SW  = 8;         // slack width
  localparam int LW  = 16;        // parallel limit width
  localparam int NDS = FB;        // divider stages

  localparam logic CFG_PARALLEL_LIMIT = 1'b0;
  localparam logic CFG_PARAM_SLACK    = 1'b1;

  // Quantities carried from the front end to the output stage.
  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
  } side_t;
endpackage

// File: hdl/segi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_front: differences, cross products and window tests.
// Four register stages; advances whenever en is high.
// ----------------------------------------------------------------------------
module segi_front (
  input  logic                                clk,
  input  logic                                en,
  input  logic [segi_pkg::LW-1:0]             parallel_limit,
  input  logic [segi_pkg::SW-1:0]             param_slack,
  input  logic signed [segi_pkg::CW-1:0]      ax,
  input  logic signed [segi_pkg::CW-1:0]      ay,
  input  logic signed [segi_pkg::CW-1:0]      bx,
  input  logic signed [segi_pkg::CW-1:0]      by_coord,
  input  logic signed [segi_pkg::CW-1:0]      cx,
  input  logic signed [segi_pkg::CW-1:0]      cy,
  input  logic signed [segi_pkg::CW-1:0]      dx,
  input  logic signed [segi_pkg::CW-1:0]      dy,
  output segi_pkg::side_t                     side,
  output logic signed [segi_pkg::XW-1:0]      den,
  output logic signed [segi_pkg::XW-1:0]      tn,
  output logic signed [segi_pkg::XW-1:0]      un
);
  localparam int DW = segi_pkg::DW;
  localparam int XW = segi_pkg::XW;
  localparam int FB = segi_pkg::FB;
  localparam int WW = XW + FB + 2;

  // Stage 1: differences.
  logic signed [DW-1:0] rx1, ry1, sx1, sy1, qx1, qy1;
  logic signed [segi_pkg::CW-1:0] ax1, ay1;
  always_ff @(posedge clk) begin
    if (en) begin
      rx1 <= DW'(bx) - DW'(ax);
      ry1 <= DW'(by_coord) - DW'(ay);
      sx1 <= DW'(dx) - DW'(cx);
      sy1 <= DW'(dy) - DW'(cy);
      qx1 <= DW'(cx) - DW'(ax);
      qy1 <= DW'(cy) - DW'(ay);
      ax1 <= ax;
      ay1 <= ay;
    end
  end

  // Stage 2: products.
  logic signed [2*DW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [DW-1:0] rx2, ry2;
  logic signed [segi_pkg::CW-1:0] ax2, ay2;
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= rx1 * sy1;
      p1 <= ry1 * sx1;
      p2 <= qx1 * sy1;
      p3 <= qy1 * sx1;
      p4 <= qx1 * ry1;
      p5 <= qy1 * rx1;
      rx2 <= rx1; ry2 <= ry1; ax2 <= ax1; ay2 <= ay1;
    end
  end

  // Stage 3: cross products, normalized to a non-negative denominator.
  logic signed [XW-1:0] d3, t3, u3;
  logic signed [DW-1:0] rx3, ry3;
  logic signed [segi_pkg::CW-1:0] ax3, ay3;
  logic signed [XW-1:0] dc, tc, uc;
  always_comb begin
    dc = XW'(p0) - XW'(p1);
    tc = XW'(p2) - XW'(p3);
    uc = XW'(p4) - XW'(p5);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d3 <= dc[XW-1] ? -dc : dc;
      t3 <= dc[XW-1] ? -tc : tc;
      u3 <= dc[XW-1] ? -uc : uc;
      rx3 <= rx2; ry3 <= ry2; ax3 <= ax2; ay3 <= ay2;
    end
  end

  // Stage 4: parallel and window tests.
  // The upper bound is den * (1 + slack), built as den shifted plus den * slack.
  logic signed [WW-1:0] lo_b, hi_b, ts, us, ds;
  logic win;
  always_comb begin
    ds = WW'(d3) * $signed({1'b0, param_slack});
    lo_b = -ds;
    hi_b = (WW'(d3) <<< FB) + ds;
    ts = WW'(t3) <<< FB;
    us = WW'(u3) <<< FB;
    win = (ts >= lo_b) && (ts <= hi_b) && (us >= lo_b) && (us <= hi_b)
          && (d3 > XW'($signed({1'b0, parallel_limit})));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side.hit <= win;
      side.ax <= ax3; side.ay <= ay3; side.rx <= rx3; side.ry <= ry3;
      den <= d3; tn <= t3; un <= u3;
    end
  end
endmodule

// File: hdl/segi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_div: pipelined restoring divider for clamped num/den.
// One quotient bit per stage; clamps to 0 or 1 are decided up front.
// ----------------------------------------------------------------------------
module segi_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [segi_pkg::XW-1:0] num,
  input  logic signed [segi_pkg::XW-1:0] den,
  output logic [segi_pkg::PW-1:0]        quo
);
  localparam int XW = segi_pkg::XW;
  localparam int N  = segi_pkg::NDS;
  localparam int PW = segi_pkg::PW;

  logic [XW:0]   rem [N+1];
  logic [XW-1:0] dv  [N+1];
  logic [PW-1:0] q   [N+1];
  logic          fx  [N+1];

  // Entry: fixed results for the clamped cases.
  always_comb begin
    dv[0] = den;
    rem[0] = {1'b0, num};
    if (num <= 0) begin
      fx[0] = 1'b1; q[0] = '0;
    end else if (num >= den) begin
      fx[0] = 1'b1; q[0] = PW'(1) << N;
    end else begin
      fx[0] = 1'b0; q[0] = '0;
    end
  end

  // One quotient bit per registered stage.
  for (genvar i = 0; i < N; i++) begin : g_st
    logic [XW:0] sh;
    always_comb sh = rem[i] << 1;
    always_ff @(posedge clk) begin
      if (en) begin
        dv[i+1] <= dv[i];
        fx[i+1] <= fx[i];
        if (!fx[i] && sh >= {1'b0, dv[i]}) begin
          rem[i+1] <= sh - {1'b0, dv[i]};
          q[i+1] <= {q[i][PW-2:0], 1'b1};
        end else begin
          rem[i+1] <= fx[i] ? rem[i] : sh;
          q[i+1] <= fx[i] ? q[i] : {q[i][PW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q[N];
endmodule

// File: hdl/segment_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection: pipelined intersection test of two 2-D segments.
// Pipeline: 4 front stages, 16 divider stages, 2 point stages.
// Throughput: one segment pair per cycle; the whole pipe holds on back pressure.
// Reset clears the stage valid bits and both configuration registers to zero.
// The divider stage count sets the latency.
// ----------------------------------------------------------------------------
module segment_intersection (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ax, ay, bx, by_coord, cx, cy, dx, dy (24 bits each, from bit 0 up)
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ix[23:0], iy[47:24], t_param[64:48], u_param[81:65], zero fill to 88
  output logic [87:0]  m_axis_tdata,
  // hit
  output logic         m_axis_tuser
);
  localparam int CW = segi_pkg::CW;
  localparam int DW = segi_pkg::DW;
  localparam int XW = segi_pkg::XW;
  localparam int PW = segi_pkg::PW;
  localparam int FB = segi_pkg::FB;
  localparam int NF = 4;
  localparam int NS = NF + segi_pkg::NDS + 2;

  logic [segi_pkg::LW-1:0] parallel_limit;
  logic [segi_pkg::SW-1:0] param_slack;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_limit <= '0;
      param_slack <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        segi_pkg::CFG_PARALLEL_LIMIT: parallel_limit <= cfg_data;
        segi_pkg::CFG_PARAM_SLACK:    param_slack <= cfg_data[7:0];
      endcase
    end
  end

  // Global stall: the pipe advances unless a full output is held.
  logic en;
  logic [NS-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NS-1];
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NS-2:0], s_axis_tvalid};
  end

  segi_pkg::side_t side;
  logic signed [XW-1:0] den, tn, un;
  segi_front u_front (
    .clk(clk), .en(en), .parallel_limit(parallel_limit), .param_slack(param_slack),
    .ax(s_axis_tdata[23:0]), .ay(s_axis_tdata[47:24]),
    .bx(s_axis_tdata[71:48]), .by_coord(s_axis_tdata[95:72]),
    .cx(s_axis_tdata[119:96]), .cy(s_axis_tdata[143:120]),
    .dx(s_axis_tdata[167:144]), .dy(s_axis_tdata[191:168]),
    .side(side), .den(den), .tn(tn), .un(un)
  );

  logic [PW-1:0] tq, uq;
  segi_div u_tdiv (.clk(clk), .en(en), .num(tn), .den(den), .quo(tq));
  segi_div u_udiv (.clk(clk), .en(en), .num(un), .den(den), .quo(uq));

  // Side data delay matching the divider.
  segi_pkg::side_t sd [segi_pkg::NDS+1];
  assign sd[0] = side;
  for (genvar i = 0; i < segi_pkg::NDS; i++) begin : g_dl
    always_ff @(posedge clk) if (en) sd[i+1] <= sd[i];
  end

  // Point stage 1: products r * t.
  localparam int MW = DW + PW + 1;
  logic signed [MW-1:0] mx, my;
  logic [PW-1:0] tq1, uq1;
  segi_pkg::side_t s1;
  always_ff @(posedge clk) begin
    if (en) begin
      mx <= MW'(sd[segi_pkg::NDS].rx) * $signed({1'b0, tq});
      my <= MW'(sd[segi_pkg::NDS].ry) * $signed({1'b0, tq});
      tq1 <= tq; uq1 <= uq; s1 <= sd[segi_pkg::NDS];
    end
  end

  // Point stage 2: round, add base, saturate.
  localparam int AW = MW + 1;
  logic signed [AW-1:0] vx, vy, px, py;
  logic signed [AW-1:0] maxv, minv;
  always_comb begin
    maxv = AW'((64'sd1 <<< (CW - 1)) - 1);
    minv = -maxv - 1;
    vx = (AW'(mx) + AW'(1 << (FB - 1))) >>> FB;
    vy = (AW'(my) + AW'(1 << (FB - 1))) >>> FB;
    px = vx + AW'(s1.ax);
    py = vy + AW'(s1.ay);
    if (px > maxv) px = maxv;
    if (px < minv) px = minv;
    if (py > maxv) py = maxv;
    if (py < minv) py = minv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tuser <= s1.hit;
      m_axis_tdata <= s1.hit ? {6'd0, uq1, tq1, py[CW-1:0], px[CW-1:0]} : '0;
    end
  end
endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for segment_intersection.
// Sends segment pairs over the input stream, predicts each hit, point and
// clamped parameter with exact wide arithmetic, and compares every output
// transfer in order. Both stream sides idle at random; the limit and slack
// registers are changed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;
  localparam int CW = segi_pkg::CW;
  localparam int PW = segi_pkg::PW;
  localparam int FB = segi_pkg::FB;

  typedef struct packed {
    logic signed [CW-1:0] dy, dx, cy, cx, by_coord, bx, ay, ax;
  } seg_pair_t;

  typedef struct packed {
    logic                 hit;
    logic [PW-1:0]        u_param;
    logic [PW-1:0]        t_param;
    logic signed [CW-1:0] iy;
    logic signed [CW-1:0] ix;
  } isect_t;

  localparam int LATENCY = 22;
  localparam longint LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = segi_pkg::CFG_PARALLEL_LIMIT;
  logic [15:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic         m_axis_tuser;

  segment_intersection dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  seg_pair_t pending_pairs[$];
  isect_t    expected_isects[$];
  int        errors = 0;
  longint    cycle = 0;
  logic [15:0] limit_reg = '0;
  logic [7:0]  slack_reg = '0;
  bit        idle_enable = 1'b0;
  bit        hold_input = 1'b0;
  logic      in_acc = 1'b0;

  // Exact prediction of one output transfer.
  function automatic isect_t predict_isect(seg_pair_t p);
    isect_t res;
    logic signed [127:0] rx, ry, sx, sy, qx, qy, den, tn, un, lo, hi;
    logic signed [127:0] tq, uq, v, q;
    logic signed [127:0] maxv, minv, px, py;
    res = '0;
    rx = p.bx - p.ax;  ry = p.by_coord - p.ay;
    sx = p.dx - p.cx;  sy = p.dy - p.cy;
    qx = p.cx - p.ax;  qy = p.cy - p.ay;
    den = rx * sy - ry * sx;
    tn  = qx * sy - qy * sx;
    un  = qx * ry - qy * rx;
    if (den < 0) begin
      den = -den; tn = -tn; un = -un;
    end
    if (den <= $signed({112'd0, limit_reg})) return res;
    lo = -(den * $signed({120'd0, slack_reg}));
    hi = den * ($signed(128'd65536) + $signed({120'd0, slack_reg}));
    if ((tn <<< FB) < lo || (tn <<< FB) > hi) return res;
    if ((un <<< FB) < lo || (un <<< FB) > hi) return res;
    tq = (tn <= 0) ? 0 : (tn >= den) ? 65536 : (tn <<< FB) / den;
    uq = (un <= 0) ? 0 : (un >= den) ? 65536 : (un <<< FB) / den;
    maxv = (128'sd1 <<< (CW - 1)) - 1;
    minv = -maxv - 1;
    v = rx * tq + 32768;
    q = v >>> FB;
    px = p.ax + q;
    v = ry * tq + 32768;
    q = v >>> FB;
    py = p.ay + q;
    if (px > maxv) px = maxv;
    if (px < minv) px = minv;
    if (py > maxv) py = maxv;
    if (py < minv) py = minv;
    res.hit = 1'b1;
    res.ix = px[CW-1:0];
    res.iy = py[CW-1:0];
    res.t_param = tq[PW-1:0];
    res.u_param = uq[PW-1:0];
    return res;
  endfunction

  // Appends one pair to the pending queue.
  function automatic void add_pair(seg_pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  // Driver: presents queued pairs at the falling edge; a new pair goes out
  // only when the line is idle or the last one was taken at the rising edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_acc) begin
        if (pending_pairs.size() > 0 && !hold_input &&
            !(idle_enable && $urandom_range(99) < 20)) begin
          s_axis_tdata  <= pending_pairs[0];
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !(idle_enable && $urandom_range(99) < 20);
    end
  end

  // Predict on accepted input; pop the driven pair.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    in_acc <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_isects.insert(expected_isects.size(),
                             predict_isect(seg_pair_t'(s_axis_tdata)));
      void'(pending_pairs.pop_front());
    end
  end

  // Monitor: compare each output transfer with the oldest expectation.
  always @(posedge clk) begin
    isect_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[81:65], m_axis_tdata[64:48],
             m_axis_tdata[47:24], m_axis_tdata[23:0]};
      if (expected_isects.size() == 0) begin
        $display("%0t: unexpected transfer %h", $realtime, got);
        errors++;
      end else begin
        want = expected_isects.pop_front();
        if (got.hit !== want.hit || got.ix !== want.ix || got.iy !== want.iy ||
            got.t_param !== want.t_param || got.u_param !== want.u_param) begin
          $display("%0t: expected hit=%b ix=%0d iy=%0d t=%0d u=%0d", $realtime,
                   want.hit, want.ix, want.iy, want.t_param, want.u_param);
          $display("%0t: actual   hit=%b ix=%0d iy=%0d t=%0d u=%0d", $realtime,
                   got.hit, got.ix, got.iy, got.t_param, got.u_param);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || s_axis_tvalid || expected_isects.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == segi_pkg::CFG_PARALLEL_LIMIT) limit_reg = val;
    else slack_reg = val[7:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(3))
      0: return CW'($urandom);
      1: return CW'($signed(CW'($urandom_range(8000))) - 4000);
      2: return CW'($signed(CW'($urandom_range(200000))) - 100000);
      default: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
    endcase
  endfunction

  // Random pair, mostly crossing segments built around a common point.
  function automatic seg_pair_t rnd_pair();
    seg_pair_t p;
    logic signed [CW-1:0] mx, my;
    int span;
    if ($urandom_range(99) < 30) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p.ax = rnd_coord(); p.dy = rnd_coord();
    end else begin
      span = $urandom_range(1) ? 4000 : 2000000;
      mx = CW'($signed(CW'($urandom_range(2 * span))) - span);
      my = CW'($signed(CW'($urandom_range(2 * span))) - span);
      p.ax = mx - $signed(CW'($urandom_range(span)));
      p.ay = CW'(my - $signed(CW'($urandom_range(span))) + span / 2);
      p.bx = CW'(2 * mx - p.ax + $signed(CW'($urandom_range(64))) - 32);
      p.by_coord = CW'(2 * my - p.ay + $signed(CW'($urandom_range(64))) - 32);
      p.cx = CW'(mx + $signed(CW'($urandom_range(span))) - span / 2);
      p.cy = my - $signed(CW'($urandom_range(span)));
      p.dx = CW'(2 * mx - p.cx + $signed(CW'($urandom_range(64))) - 32);
      p.dy = CW'(2 * my - p.cy + $signed(CW'($urandom_range(64))) - 32);
    end
    return p;
  endfunction

  function automatic seg_pair_t mk(int a, int b, int c, int d, int e, int f,
                                   int g, int h);
    seg_pair_t p;
    p.ax = CW'(a); p.ay = CW'(b); p.bx = CW'(c); p.by_coord = CW'(d);
    p.cx = CW'(e); p.cy = CW'(f); p.dx = CW'(g); p.dy = CW'(h);
    return p;
  endfunction

  initial begin
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: plain crossing, endpoints, parallel, degenerate, extremes.
    add_pair(mk(0, 0, 256, 256, 0, 256, 256, 0));
    add_pair(mk(0, 0, 256, 0, 256, -256, 256, 256));
    add_pair(mk(0, 0, 256, 0, 0, 0, 0, 256));
    add_pair(mk(0, 0, 256, 0, 0, 10, 256, 10));
    add_pair(mk(5, 5, 5, 5, 0, 0, 256, 256));
    add_pair(mk(0, 0, 256, 0, 300, -256, 300, 256));
    add_pair(mk(0, 0, 256, 0, 257, -256, 257, 256));
    add_pair(mk(mn, mn, mx, mx, mn, mx, mx, mn));
    add_pair(mk(mx, mn, mn, mx, mn, mn, mx, mx));
    add_pair(mk(mn, 0, mx, 0, 0, mn, 0, mx));
    add_pair(mk(mx, mx, mn, mn, mx, mn, mn, mx));
    add_pair(mk(0, 0, 1, 1, 0, 1, 1, 0));
    add_pair(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    add_pair(mk(0, 0, 3, 1, 1, 0, 2, 3));
    wait_drained();

    // Tolerance and parallel limit at their top values.
    write_reg(segi_pkg::CFG_PARAM_SLACK, 16'hff);
    write_reg(segi_pkg::CFG_PARALLEL_LIMIT, 16'hffff);
    add_pair(mk(0, 0, 256, 0, 257, -256, 257, 256));
    add_pair(mk(0, 0, 256, 0, -1, -256, -1, 256));
    add_pair(mk(0, 0, 1, 1, 0, 1, 1, 0));
    add_pair(mk(0, 0, 256, 256, 0, 256, 256, 0));
    add_pair(mk(0, 0, 1024, 0, 512, -1024, 512, 1024));
    wait_drained();

    // Random phases over several register settings.
    idle_enable = 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(segi_pkg::CFG_PARALLEL_LIMIT, 16'd0);
          write_reg(segi_pkg::CFG_PARAM_SLACK, 16'd0);
        end
        1: begin
          write_reg(segi_pkg::CFG_PARALLEL_LIMIT, 16'($urandom));
          write_reg(segi_pkg::CFG_PARAM_SLACK, 16'($urandom));
        end
        2: begin
          write_reg(segi_pkg::CFG_PARALLEL_LIMIT, 16'hffff);
          write_reg(segi_pkg::CFG_PARAM_SLACK, 16'hff);
        end
        3: begin
          write_reg(segi_pkg::CFG_PARALLEL_LIMIT, 16'd1);
          write_reg(segi_pkg::CFG_PARAM_SLACK, 16'd1);
        end
        default: begin
          write_reg(segi_pkg::CFG_PARALLEL_LIMIT, 16'($urandom_range(300)));
          write_reg(segi_pkg::CFG_PARAM_SLACK, 16'($urandom_range(255)));
        end
      endcase
      for (int i = 0; i < 125; i++) add_pair(rnd_pair());
      idle_enable = (ph != 0);
      if (ph == 3) begin
        // Hold the input until the pipeline has emptied, then resume.
        while (pending_pairs.size() > 60) @(posedge clk);
        @(negedge clk);
        hold_input <= 1'b1;
        while (expected_isects.size() > 0) @(posedge clk);
        @(negedge clk);
        hold_input <= 1'b0;
      end
      wait_drained();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
